// ===== design/miu_pkg.sv =====
package miu_pkg;

   localparam int WORD_BITS_DEFAULT = 32;
   localparam int STATUS_BITS = 2;

   typedef enum logic [STATUS_BITS-1:0] {
      STATUS_OK          = 2'd0,
      STATUS_NOT_COPRIME = 2'd1,
      STATUS_SMALL_MOD   = 2'd2,
      STATUS_ZERO_BASE   = 2'd3
   } status_type;

   // datapath operations issued by the controller
   typedef enum logic [2:0] {
      OP_LOAD    = 3'd0,  // capture operands
      OP_GCD     = 3'd1,  // start next gcd division a % b
      OP_REDUCE  = 3'd2,  // start base % m
      OP_STEP    = 3'd3,  // start m / b for one reduction round
      OP_MULT    = 3'd4,  // start acc * factor mod m
      OP_NONE    = 3'd5
   } op_type;

   typedef struct packed {
      logic   issue;
      op_type op;
   } cmd_type;

   typedef struct packed {
      logic unit_busy;   // a division or product is running
      logic gcd_b_zero;  // gcd divisor has reached zero
      logic mod_small;   // modulus below 2
      logic gcd_one;     // gcd equals one
      logic b_zero;      // current base is zero
      logic b_one;       // current base is one
   } status_flags_type;

endpackage

// ===== design/modular_inverse_unit_top.sv =====
// Channel   Direction  Ports                                   Handshake
// request   in         req_base_value, req_modulus_value       start && !busy
// response  out        rsp_inverse_value, rsp_common_divisor,  rsp_valid, one cycle
//                      rsp_result_status
//
// One request at a time; operands are captured at the accepting edge and busy stays
// high from acceptance until the response cycle. A request runs the Euclid divisions
// and a gcd check, then, for a coprime pair with a modulus of at least 2, reduces the
// base and runs reduction rounds, each one bit-serial division and a shift-and-add
// product. Synchronous reset clears control only. The response cannot be stalled.
module modular_inverse_unit_top #(
   parameter int WORD_BITS = miu_pkg::WORD_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [31:0] req_base_value,
   input  logic [31:0] req_modulus_value,
   output logic        rsp_valid,
   output logic [31:0] rsp_inverse_value,
   output logic [31:0] rsp_common_divisor,
   output logic [1:0]  rsp_result_status
);

   miu_pkg::cmd_type          cmd;
   miu_pkg::status_flags_type flags;
   miu_pkg::status_type       status;
   logic                      zero_inv;
   logic [31:0]               inv, gcd;

   miu_control u_control (
      .clock            (clock),
      .reset            (reset),
      .req_start        (start),
      .flags            (flags),
      .busy             (busy),
      .cmd              (cmd),
      .rsp_valid        (rsp_valid),
      .rsp_status       (status),
      .rsp_zero_inverse (zero_inv)
   );

   miu_datapath #(.WORD_BITS(WORD_BITS)) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_base_value    (req_base_value),
      .req_modulus_value (req_modulus_value),
      .flags             (flags),
      .inverse_value     (inv),
      .common_divisor    (gcd)
   );

   assign rsp_inverse_value  = zero_inv ? 32'd0 : inv;
   assign rsp_common_divisor = gcd;
   assign rsp_result_status  = status;

endmodule

// ===== design/miu_datapath.sv =====
module miu_datapath #(
   parameter int WORD_BITS = miu_pkg::WORD_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  miu_pkg::cmd_type          cmd,
   input  logic [31:0]               req_base_value,
   input  logic [31:0]               req_modulus_value,
   output miu_pkg::status_flags_type flags,
   output logic [31:0]               inverse_value,
   output logic [31:0]               common_divisor
);

   localparam int CNT_BITS = $clog2(WORD_BITS + 1);

   typedef enum logic [1:0] {
      UNIT_IDLE,
      UNIT_DIV,
      UNIT_MUL
   } unit_type;

   typedef enum logic [1:0] {
      DEST_GCD,
      DEST_REDUCE,
      DEST_STEP
   } dest_type;

   unit_type unit_ff, unit_in;
   dest_type dest_ff, dest_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;

   logic [WORD_BITS-1:0] base_ff, base_in;     // masked original base
   logic [WORD_BITS-1:0] m_ff, m_in;
   logic [WORD_BITS-1:0] ga_ff, ga_in;
   logic [WORD_BITS-1:0] gb_ff, gb_in;
   logic [WORD_BITS-1:0] b_ff, b_in;
   logic [WORD_BITS-1:0] acc_ff, acc_in;
   logic [WORD_BITS-1:0] fac_ff, fac_in;

   // restoring divider: remainder, quotient/dividend shift register, divisor
   logic [WORD_BITS-1:0] rem_ff, rem_in;
   logic [WORD_BITS-1:0] quo_ff, quo_in;
   logic [WORD_BITS-1:0] dvs_ff, dvs_in;

   // shift-and-add product: multiplicand doubling, multiplier bits, sum
   logic [WORD_BITS-1:0] ma_ff, ma_in;
   logic [WORD_BITS-1:0] mb_ff, mb_in;
   logic [WORD_BITS-1:0] ms_ff, ms_in;

   logic [WORD_BITS:0]   trial;
   logic [WORD_BITS-1:0] rem_sh;
   logic [WORD_BITS-1:0] div_rem, div_quo, step_bmr;
   logic [WORD_BITS-1:0] sum_add, dbl_add;

   function automatic logic [WORD_BITS-1:0] add_mod(
      input logic [WORD_BITS-1:0] x,
      input logic [WORD_BITS-1:0] y,
      input logic [WORD_BITS-1:0] m
   );
      logic [WORD_BITS-1:0] room;
      room = m - y;
      add_mod = (x >= room) ? (x - room) : (x + y);
   endfunction

   always_comb begin
      trial    = {rem_ff, quo_ff[WORD_BITS-1]} - {1'b0, dvs_ff};
      rem_sh   = {rem_ff[WORD_BITS-2:0], quo_ff[WORD_BITS-1]};
      div_rem  = trial[WORD_BITS] ? rem_sh : trial[WORD_BITS-1:0];
      div_quo  = {quo_ff[WORD_BITS-2:0], ~trial[WORD_BITS]};
      step_bmr = b_ff - div_rem;
      sum_add  = add_mod(ms_ff, ma_ff, m_ff);
      dbl_add  = add_mod(ma_ff, ma_ff, m_ff);
   end

   always_comb begin
      unit_in = unit_ff;
      dest_in = dest_ff;
      cnt_in  = cnt_ff;
      base_in = base_ff;
      m_in    = m_ff;
      ga_in   = ga_ff;
      gb_in   = gb_ff;
      b_in    = b_ff;
      acc_in  = acc_ff;
      fac_in  = fac_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      ma_in   = ma_ff;
      mb_in   = mb_ff;
      ms_in   = ms_ff;
      case (unit_ff)
         UNIT_DIV: begin
            if (!trial[WORD_BITS]) begin
               rem_in = trial[WORD_BITS-1:0];
               quo_in = {quo_ff[WORD_BITS-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[WORD_BITS-2:0], 1'b0};
            end
            cnt_in = cnt_ff - CNT_BITS'(1);
            if (cnt_ff == CNT_BITS'(1)) begin
               unit_in = UNIT_IDLE;
            end
         end
         UNIT_MUL: begin
            if (mb_ff == '0) begin
               acc_in  = ms_ff;
               unit_in = UNIT_IDLE;
            end else begin
               if (mb_ff[0]) begin
                  ms_in = sum_add;
               end
               ma_in = dbl_add;
               mb_in = mb_ff >> 1;
            end
         end
         default: begin
            // start the commanded operation
            if (cmd.issue) begin
               case (cmd.op)
                  miu_pkg::OP_LOAD: begin
                     base_in = WORD_BITS'(req_base_value);
                     m_in    = WORD_BITS'(req_modulus_value);
                     ga_in   = WORD_BITS'(req_base_value);
                     gb_in   = WORD_BITS'(req_modulus_value);
                     acc_in  = WORD_BITS'(1);
                  end
                  miu_pkg::OP_GCD: begin
                     rem_in  = '0;
                     quo_in  = ga_ff;
                     dvs_in  = gb_ff;
                     cnt_in  = CNT_BITS'(WORD_BITS);
                     dest_in = DEST_GCD;
                     unit_in = UNIT_DIV;
                  end
                  miu_pkg::OP_REDUCE: begin
                     rem_in  = '0;
                     quo_in  = base_ff;
                     dvs_in  = m_ff;
                     cnt_in  = CNT_BITS'(WORD_BITS);
                     dest_in = DEST_REDUCE;
                     unit_in = UNIT_DIV;
                  end
                  miu_pkg::OP_STEP: begin
                     rem_in  = '0;
                     quo_in  = m_ff;
                     dvs_in  = b_ff;
                     cnt_in  = CNT_BITS'(WORD_BITS);
                     dest_in = DEST_STEP;
                     unit_in = UNIT_DIV;
                  end
                  miu_pkg::OP_MULT: begin
                     // acc and factor are already below m
                     ma_in   = acc_ff;
                     mb_in   = fac_ff;
                     ms_in   = '0;
                     unit_in = UNIT_MUL;
                  end
                  default: begin
                  end
               endcase
            end
         end
      endcase
      // write back a finished division
      if (unit_ff == UNIT_DIV && cnt_ff == CNT_BITS'(1)) begin
         case (dest_ff)
            DEST_GCD: begin
               ga_in = gb_ff;
               gb_in = div_rem;
            end
            DEST_REDUCE: begin
               b_in = div_rem;
            end
            default: begin
               // one reduction round: pick nearer remainder, set the product factor
               if (div_rem < step_bmr) begin
                  b_in   = div_rem;
                  fac_in = m_ff - div_quo;
               end else begin
                  b_in   = step_bmr;
                  fac_in = div_quo + WORD_BITS'(1);
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ff <= UNIT_IDLE;
         cnt_ff  <= '0;
         dest_ff <= DEST_GCD;
      end else begin
         unit_ff <= unit_in;
         cnt_ff  <= cnt_in;
         dest_ff <= dest_in;
      end
      base_ff <= base_in;
      m_ff    <= m_in;
      ga_ff   <= ga_in;
      gb_ff   <= gb_in;
      b_ff    <= b_in;
      acc_ff  <= acc_in;
      fac_ff  <= fac_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dvs_ff  <= dvs_in;
      ma_ff   <= ma_in;
      mb_ff   <= mb_in;
      ms_ff   <= ms_in;
   end

   assign flags.unit_busy  = (unit_ff != UNIT_IDLE);
   assign flags.gcd_b_zero = (gb_ff == '0);
   assign flags.mod_small  = (m_ff < WORD_BITS'(2));
   assign flags.gcd_one    = (ga_ff == WORD_BITS'(1));
   assign flags.b_zero     = (b_ff == '0);
   assign flags.b_one      = (b_ff == WORD_BITS'(1));

   assign inverse_value  = 32'(acc_ff);
   assign common_divisor = 32'(ga_ff);

endmodule

// ===== design/miu_control.sv =====
module miu_control (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_start,
   input  miu_pkg::status_flags_type flags,
   output logic                      busy,
   output miu_pkg::cmd_type          cmd,
   output logic                      rsp_valid,
   output miu_pkg::status_type       rsp_status,
   output logic                      rsp_zero_inverse
);

   typedef enum logic [2:0] {
      S_IDLE,
      S_GCD,
      S_CHECK,
      S_REDUCE,
      S_LOOP,
      S_MULT
   } state_type;

   state_type state_ff, state_in;
   logic busy_ff, busy_in, valid_ff, valid_in, zero_ff, zero_in;
   miu_pkg::status_type status_ff, status_in;
   miu_pkg::cmd_type cmd_ff, cmd_in;
   logic unit_free;
   logic load_now;

   // capture the operands at the accepting edge itself
   assign load_now = (state_ff == S_IDLE) && req_start;

   always_comb begin
      unit_free = !flags.unit_busy && !cmd_ff.issue;
      state_in  = state_ff;
      busy_in   = busy_ff;
      valid_in  = 1'b0;
      zero_in   = zero_ff;
      status_in = status_ff;
      cmd_in    = '{issue: 1'b0, op: miu_pkg::OP_NONE};
      case (state_ff)
         S_IDLE: begin
            if (req_start) begin
               busy_in  = 1'b1;
               state_in = S_GCD;
            end
         end
         S_GCD: begin
            if (unit_free) begin
               if (flags.gcd_b_zero) begin
                  state_in = S_CHECK;
               end else begin
                  cmd_in = '{issue: 1'b1, op: miu_pkg::OP_GCD};
               end
            end
         end
         S_CHECK: begin
            if (flags.mod_small || !flags.gcd_one) begin
               status_in = flags.mod_small ? miu_pkg::STATUS_SMALL_MOD
                                           : miu_pkg::STATUS_NOT_COPRIME;
               zero_in   = 1'b1;
               valid_in  = 1'b1;
               busy_in   = 1'b0;
               state_in  = S_IDLE;
            end else begin
               cmd_in   = '{issue: 1'b1, op: miu_pkg::OP_REDUCE};
               state_in = S_REDUCE;
            end
         end
         S_REDUCE: begin
            if (unit_free) begin
               state_in = S_LOOP;
            end
         end
         S_MULT: begin
            // chain the product straight after a reduction division
            if (unit_free) begin
               cmd_in   = '{issue: 1'b1, op: miu_pkg::OP_MULT};
               state_in = S_REDUCE;
            end
         end
         S_LOOP: begin
            if (unit_free) begin
               if (flags.b_one) begin
                  status_in = miu_pkg::STATUS_OK;
                  zero_in   = 1'b0;
                  valid_in  = 1'b1;
                  busy_in   = 1'b0;
                  state_in  = S_IDLE;
               end else if (flags.b_zero) begin
                  status_in = miu_pkg::STATUS_ZERO_BASE;
                  zero_in   = 1'b1;
                  valid_in  = 1'b1;
                  busy_in   = 1'b0;
                  state_in  = S_IDLE;
               end else begin
                  cmd_in   = '{issue: 1'b1, op: miu_pkg::OP_STEP};
                  state_in = S_MULT;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         busy_ff   <= 1'b0;
         valid_ff  <= 1'b0;
         zero_ff   <= 1'b0;
         status_ff <= miu_pkg::STATUS_OK;
         cmd_ff    <= '{issue: 1'b0, op: miu_pkg::OP_NONE};
      end else begin
         state_ff  <= state_in;
         busy_ff   <= busy_in;
         valid_ff  <= valid_in;
         zero_ff   <= zero_in;
         status_ff <= status_in;
         cmd_ff    <= cmd_in;
      end
   end

   assign busy             = busy_ff;
   assign cmd              = load_now ? '{issue: 1'b1, op: miu_pkg::OP_LOAD} : cmd_ff;
   assign rsp_valid        = valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_zero_inverse = zero_ff;

endmodule

// ===== design/miu_checker.sv =====
module miu_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic [31:0] rsp_inverse_value,
   input logic [1:0]  rsp_result_status
);

   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("request accepted but busy not raised");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while still busy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_status != miu_pkg::STATUS_OK |-> rsp_inverse_value == 32'd0)
      else $error("non-zero inverse on failed request");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("response strobe longer than one cycle");

endmodule

bind modular_inverse_unit_top miu_checker u_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .rsp_valid         (rsp_valid),
   .rsp_inverse_value (rsp_inverse_value),
   .rsp_result_status (rsp_result_status)
);

// ===== tb/sv/testbench.sv =====
module testbench;

   typedef struct {
      logic [31:0] base_value;
      logic [31:0] modulus_value;
   } inv_request_type;

   typedef struct {
      logic [31:0]         inverse_value;
      logic [31:0]         common_divisor;
      miu_pkg::status_type result_status;
   } inv_result_type;

   localparam int CYCLE_LIMIT = 2000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [31:0] req_base_value = '0;
   logic [31:0] req_modulus_value = '0;
   logic        rsp_valid;
   logic [31:0] rsp_inverse_value;
   logic [31:0] rsp_common_divisor;
   logic [1:0]  rsp_result_status;

   inv_request_type pending_requests[$];
   inv_result_type  expected_results[$];
   int           idle_percent = 0;
   int           error_count = 0;
   int           accepted_count = 0;
   int           checked_count = 0;
   int           ok_count = 0;
   int           zero_base_count = 0;
   int           cycle_count = 0;

   modular_inverse_unit_top dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_base_value(req_base_value), .req_modulus_value(req_modulus_value),
      .rsp_valid(rsp_valid), .rsp_inverse_value(rsp_inverse_value),
      .rsp_common_divisor(rsp_common_divisor), .rsp_result_status(rsp_result_status)
   );

   always #5 clock = ~clock;

   function automatic logic [63:0] gcd_words(logic [63:0] a, logic [63:0] b);
      logic [63:0] t;
      while (b != 0) begin
         t = a % b;
         a = b;
         b = t;
      end
      return a;
   endfunction

   function automatic inv_result_type predict_inverse(inv_request_type req);
      inv_result_type res;
      logic [63:0] m, b, q, r, acc;
      m = 64'(req.modulus_value);
      res.inverse_value = '0;
      res.common_divisor = 32'(gcd_words(64'(req.base_value), m));
      res.result_status = miu_pkg::STATUS_OK;
      if (m < 2) begin
         res.result_status = miu_pkg::STATUS_SMALL_MOD;
      end else if (res.common_divisor != 1) begin
         res.result_status = miu_pkg::STATUS_NOT_COPRIME;
      end else begin
         b = 64'(req.base_value) % m;
         acc = 1;
         while (b != 1 && res.result_status == miu_pkg::STATUS_OK) begin
            if (b == 0) begin
               res.result_status = miu_pkg::STATUS_ZERO_BASE;
            end else begin
               q = m / b;
               r = m % b;
               // products stay below 2**64 since both factors fit 32 bits
               if (r < b - r) begin
                  b = r;
                  acc = (acc * (m - q)) % m;
               end else begin
                  b = b - r;
                  acc = (acc * (q + 1)) % m;
               end
            end
         end
         if (res.result_status == miu_pkg::STATUS_OK)
            res.inverse_value = 32'(acc % m);
      end
      return res;
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 20);
         1: return 32'hFFFF_FFFF - $urandom_range(0, 20);
         2: return $urandom & 32'hFFFF;
         default: return $urandom;
      endcase
   endfunction

   task automatic push_request(logic [31:0] base_value, logic [31:0] modulus_value);
      inv_request_type req;
      req.base_value = base_value;
      req.modulus_value = modulus_value;
      pending_requests.push_back(req);
   endtask

   task automatic wait_drained();
      while (pending_requests.size() != 0 || expected_results.size() != 0 || busy)
         @(posedge clock);
   endtask

   // driver: present a request at the falling edge, hold it until accepted
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (start && busy) begin
         start <= 1'b1;
      end else if (pending_requests.size() != 0 &&
                   $urandom_range(0, 99) >= idle_percent) begin
         start <= 1'b1;
         req_base_value <= pending_requests[0].base_value;
         req_modulus_value <= pending_requests[0].modulus_value;
      end else begin
         start <= 1'b0;
         req_base_value <= $urandom;
         req_modulus_value <= $urandom;
      end
   end

   // monitor: record accepted requests, check each response
   always @(posedge clock) begin
      inv_result_type exp_res;
      inv_request_type req;
      cycle_count = cycle_count + 1;
      if (!reset && start && !busy) begin
         req = pending_requests.pop_front();
         expected_results.push_back(predict_inverse(req));
         accepted_count = accepted_count + 1;
      end
      if (!reset && rsp_valid) begin
         if (expected_results.size() == 0) begin
            $error("response with no request outstanding");
            error_count = error_count + 1;
         end else begin
            exp_res = expected_results.pop_front();
            checked_count = checked_count + 1;
            if (exp_res.result_status == miu_pkg::STATUS_OK) ok_count = ok_count + 1;
            if (exp_res.result_status == miu_pkg::STATUS_ZERO_BASE)
               zero_base_count = zero_base_count + 1;
            if (rsp_inverse_value !== exp_res.inverse_value) begin
               $error("inverse_value: expected %0d, got %0d",
                      exp_res.inverse_value, rsp_inverse_value);
               error_count = error_count + 1;
            end
            if (rsp_common_divisor !== exp_res.common_divisor) begin
               $error("common_divisor: expected %0d, got %0d",
                      exp_res.common_divisor, rsp_common_divisor);
               error_count = error_count + 1;
            end
            if (rsp_result_status !== exp_res.result_status) begin
               $error("result_status: expected %0d, got %0d",
                      exp_res.result_status, rsp_result_status);
               error_count = error_count + 1;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      int phase_idle[4] = '{0, 83, 0, 35};
      logic [31:0] mod_pick;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: small moduli, zero operands, extremes, non-coprime, zero-base cases
      push_request(32'd5, 32'd0);
      push_request(32'd0, 32'd0);
      push_request(32'd7, 32'd1);
      push_request(32'd0, 32'd1);
      push_request(32'hFFFF_FFFF, 32'd0);
      push_request(32'd0, 32'd7);
      push_request(32'd1, 32'd2);
      push_request(32'd3, 32'd7);
      push_request(32'd6, 32'd9);
      push_request(32'd4, 32'd8);
      push_request(32'd3, 32'd8);
      push_request(32'd7, 32'd15);
      push_request(32'd2, 32'd15);
      push_request(32'd7, 32'd12);
      push_request(32'hFFFF_FFFF, 32'hFFFF_FFFE);
      push_request(32'hFFFF_FFFE, 32'hFFFF_FFFF);
      push_request(32'h1234_5679, 32'hFFFF_FFFB);
      push_request(32'd2, 32'hFFFF_FFFF);
      push_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      push_request(32'h8000_0000, 32'h7FFF_FFFF);
      push_request(32'd100, 32'd101);
      wait_drained();

      for (int p = 0; p < 4; p++) begin
         idle_percent = phase_idle[p];
         for (int i = 0; i < 32; i++) begin
            // favour odd moduli, which make coprime pairs likelier, to reach the reduction rounds
            mod_pick = rand_word();
            if ($urandom_range(0, 3) != 0) mod_pick[0] = 1'b1;
            if ($urandom_range(0, 9) == 0) mod_pick = $urandom_range(0, 1);
            push_request(rand_word(), mod_pick);
         end
         wait_drained();
      end
      repeat (20) @(posedge clock);

      $display("%0d requests accepted, %0d responses checked", accepted_count,
               checked_count);
      $display("%0d inverses found, %0d reductions reached zero", ok_count,
               zero_base_count);
      if (error_count == 0 && expected_results.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
